// ===== rtl/lrup_pkg.sv =====
// Shared types and constants of the LRU page replacement block.
`default_nettype none

package lrup_pkg;

    localparam int PAGE_NUMBER_W  = 5;
    localparam int FRAME_INDEX_W  = 5;
    localparam int CFG_W          = 6;
    localparam int FAULT_COUNT_W  = 16;
    localparam int STAMP_W        = 32;

    localparam int NUM_PAGES_DEF  = 32;
    localparam int NUM_FRAMES_DEF = 32;

    localparam logic [CFG_W-1:0]         FRAMES_IN_USE_RESET = CFG_W'(4);
    localparam logic [FAULT_COUNT_W-1:0] FAULT_COUNT_MAX     = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } lrup_state_t;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic start;
        logic cmp_en;
    } lrup_scan_ctrl_t;

    // Flags reported by the compare unit after a full pass.
    typedef struct packed {
        logic hit;
        logic found_free;
    } lrup_scan_status_t;

endpackage

`default_nettype wire

// ===== rtl/lrup_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none

interface lrup_req_if import lrup_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PAGE_NUMBER_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrup_rsp_if import lrup_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     fault;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_NUMBER_W-1:0] evicted_page;
    logic [FAULT_COUNT_W-1:0] fault_count;

    modport source (output valid, output fault, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

interface lrup_cfg_if import lrup_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrup_frame_mem.sv =====
// Frame table memory: page and last-use stamp of each frame, registered read.
`default_nettype none

module lrup_frame_mem
    import lrup_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int FW         = 5,
    parameter int PW         = 5
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [FW-1:0]      wr_addr,
    input  wire logic [PW-1:0]      wr_page,
    input  wire logic [STAMP_W-1:0] wr_stamp,
    input  wire logic [FW-1:0]      rd_addr,
    output logic      [PW-1:0]      rd_page,
    output logic      [STAMP_W-1:0] rd_stamp
);

    logic [PW+STAMP_W-1:0] mem [NUM_FRAMES];
    logic [PW+STAMP_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_page, wr_stamp};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_page  = rd_data_reg[PW+STAMP_W-1:STAMP_W];
    assign rd_stamp = rd_data_reg[STAMP_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/lrup_scan_unit.sv =====
// Compare unit: visits one frame per cycle, tracking hit, first free and oldest frame.
`default_nettype none

module lrup_scan_unit
    import lrup_pkg::*;
#(
    parameter int FW = 5,
    parameter int PW = 5,
    parameter int CW = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrup_scan_ctrl_t    ctrl,
    input  wire logic [FW-1:0]      cmp_frame,
    input  wire logic               cmp_used,
    input  wire logic [PW-1:0]      cmp_page,
    input  wire logic [STAMP_W-1:0] cmp_stamp,
    input  wire logic [PW-1:0]      page,
    input  wire logic [CW-1:0]      active,
    input  wire logic [STAMP_W-1:0] access_clock,
    output lrup_scan_status_t       status,
    output logic      [FW-1:0]      hit_frame,
    output logic      [FW-1:0]      free_frame,
    output logic      [FW-1:0]      oldest_frame,
    output logic      [PW-1:0]      oldest_page
);

    logic                 hit_reg, hit_next;
    logic                 free_reg, free_next;
    logic                 have_old_reg, have_old_next;
    logic [STAMP_W-1:0]   old_age_reg, old_age_next;
    logic [FW-1:0]        hit_frame_reg, hit_frame_next;
    logic [FW-1:0]        free_frame_reg, free_frame_next;
    logic [FW-1:0]        old_frame_reg, old_frame_next;
    logic [PW-1:0]        old_page_reg, old_page_next;
    logic [STAMP_W-1:0]   age;
    logic                 in_range;

    // Age under wrap is the modular difference; the largest is the oldest.
    assign age      = access_clock - cmp_stamp;
    assign in_range = CW'(cmp_frame) < active;

    always_comb
    begin
        hit_next        = hit_reg;
        free_next       = free_reg;
        have_old_next   = have_old_reg;
        old_age_next    = old_age_reg;
        hit_frame_next  = hit_frame_reg;
        free_frame_next = free_frame_reg;
        old_frame_next  = old_frame_reg;
        old_page_next   = old_page_reg;
        if (ctrl.start)
        begin
            hit_next      = 1'b0;
            free_next     = 1'b0;
            have_old_next = 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            // Residency is checked over every frame, so pages left above a
            // reduced frame count still hit.
            if (cmp_used && cmp_page == page)
            begin
                hit_next       = 1'b1;
                hit_frame_next = cmp_frame;
            end
            if (in_range && !cmp_used && !free_reg)
            begin
                free_next       = 1'b1;
                free_frame_next = cmp_frame;
            end
            if (in_range && cmp_used && (!have_old_reg || age > old_age_reg))
            begin
                have_old_next  = 1'b1;
                old_age_next   = age;
                old_frame_next = cmp_frame;
                old_page_next  = cmp_page;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            have_old_reg <= 1'b0;
        end
        else
        begin
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            have_old_reg <= have_old_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_age_reg    <= old_age_next;
        hit_frame_reg  <= hit_frame_next;
        free_frame_reg <= free_frame_next;
        old_frame_reg  <= old_frame_next;
        old_page_reg   <= old_page_next;
    end

    assign status.hit        = hit_reg;
    assign status.found_free = free_reg;
    assign hit_frame         = hit_frame_reg;
    assign free_frame        = free_frame_reg;
    assign oldest_frame      = old_frame_reg;
    assign oldest_page       = old_page_reg;

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: sequencer, frame state and result register.
//
// Each request on req carries one page number; each produces exactly one result on rsp:
// fault flag, the frame now holding the page, the evicted page if any, and the saturating
// count of faults since reset. The cfg channel writes frames_in_use, the number of frames
// the policy may fill or evict; it is always ready, and the user must write it only while
// the block is idle, which the block itself does not enforce.
// A request is accepted only in the idle state. The shared compare unit then visits every
// frame, one per cycle, reading the frame memory through its single registered port: it
// looks for the page, the first free frame in range and the oldest used frame in range.
// The block accepts no new request until the current one has committed its result.
//
// The result sits in an output register; if the receiver stalls, the next request is
// still accepted and scanned, and its commit waits until the register is free.
// Reset clears the frame-used flags, the access clock, the fault count and the output valid
// flag, and sets frames_in_use to 4; no clearing pass is needed.
`default_nettype none

module lru_page_replacement
    import lrup_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lrup_cfg_if.sink    cfg,
    lrup_req_if.sink    req,
    lrup_rsp_if.source  rsp
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);

    lrup_state_t              state_reg, state_next;
    logic [CFG_W-1:0]         frames_in_use_reg;
    logic [PW-1:0]            page_reg;
    logic [CW-1:0]            active_reg;
    logic [FW-1:0]            idx_reg;
    logic                     cmp_en_reg;
    logic [FW-1:0]            cmp_idx_reg;
    logic [NUM_FRAMES-1:0]    used_reg;
    logic [STAMP_W-1:0]       clock_reg;
    logic [FAULT_COUNT_W-1:0] faults_reg;

    logic                     out_valid_reg;
    logic                     out_fault_reg;
    logic [FRAME_INDEX_W-1:0] out_frame_reg;
    logic                     out_ev_valid_reg;
    logic [PAGE_NUMBER_W-1:0] out_ev_page_reg;
    logic [FAULT_COUNT_W-1:0] out_count_reg;

    logic                     accept;
    logic                     commit;
    lrup_scan_ctrl_t          scan_ctrl;
    lrup_scan_status_t        scan_status;
    logic [PW-1:0]            page_in;
    logic [CW-1:0]            active_in;
    logic [31:0]              cfg_wide;
    logic [PW-1:0]            rd_page;
    logic [STAMP_W-1:0]       rd_stamp;
    logic [FW-1:0]            hit_frame;
    logic [FW-1:0]            free_frame;
    logic [FW-1:0]            oldest_frame;
    logic [PW-1:0]            oldest_page;
    logic [FW-1:0]            frame_sel;
    logic                     evict;
    logic [FAULT_COUNT_W-1:0] faults_new;

    assign cfg.ready = 1'b1;

    // Page numbers beyond the page count wrap; each candidate value maps through a fixed table.
    always_comb
    begin
        page_in = '0;
        for (int i = 0; i < 2 ** PAGE_NUMBER_W; i++)
        begin
            if (req.page_number == PAGE_NUMBER_W'(i))
            begin
                page_in = PW'(i % NUM_PAGES);
            end
        end
    end

    // A frame count of zero acts as one, and one above the frame total as the total.
    always_comb
    begin
        cfg_wide = 32'(frames_in_use_reg);
        if (frames_in_use_reg == '0)
        begin
            active_in = CW'(1);
        end
        else if (cfg_wide > 32'(NUM_FRAMES))
        begin
            active_in = CW'(NUM_FRAMES);
        end
        else
        begin
            active_in = CW'(cfg_wide);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_FRAME)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready        = 1'b0;
        commit           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_FINISH:
            begin
                commit = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept           = req.valid && req.ready;
    assign scan_ctrl.start  = accept;
    assign scan_ctrl.cmp_en = cmp_en_reg;

    always_comb
    begin
        evict = 1'b0;
        if (scan_status.hit)
        begin
            frame_sel = hit_frame;
        end
        else if (scan_status.found_free)
        begin
            frame_sel = free_frame;
        end
        else
        begin
            frame_sel = oldest_frame;
            evict     = 1'b1;
        end
        faults_new = faults_reg;
        if (!scan_status.hit && faults_reg != FAULT_COUNT_MAX)
        begin
            faults_new = faults_reg + FAULT_COUNT_W'(1);
        end
    end

    lrup_frame_mem #(
        .NUM_FRAMES (NUM_FRAMES),
        .FW         (FW),
        .PW         (PW)
    ) u_frame_mem (
        .clk      (clk),
        .wr_en    (commit),
        .wr_addr  (frame_sel),
        .wr_page  (page_reg),
        .wr_stamp (clock_reg),
        .rd_addr  (idx_reg),
        .rd_page  (rd_page),
        .rd_stamp (rd_stamp)
    );

    lrup_scan_unit #(
        .FW (FW),
        .PW (PW),
        .CW (CW)
    ) u_scan_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (scan_ctrl),
        .cmp_frame    (cmp_idx_reg),
        .cmp_used     (used_reg[cmp_idx_reg]),
        .cmp_page     (rd_page),
        .cmp_stamp    (rd_stamp),
        .page         (page_reg),
        .active       (active_reg),
        .access_clock (clock_reg),
        .status       (scan_status),
        .hit_frame    (hit_frame),
        .free_frame   (free_frame),
        .oldest_frame (oldest_frame),
        .oldest_page  (oldest_page)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            idx_reg           <= '0;
            cmp_en_reg        <= 1'b0;
            cmp_idx_reg       <= '0;
            used_reg          <= '0;
            clock_reg         <= '0;
            faults_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_en_reg  <= (state_reg == ST_SCAN);
            cmp_idx_reg <= idx_reg;
            if (cfg.valid && cfg.ready)
            begin
                frames_in_use_reg <= cfg.frames_in_use;
            end
            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN && idx_reg != LAST_FRAME)
            begin
                idx_reg <= idx_reg + FW'(1);
            end
            if (commit)
            begin
                used_reg[frame_sel] <= 1'b1;
                clock_reg           <= clock_reg + STAMP_W'(1);
                faults_reg          <= faults_new;
                out_valid_reg       <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= page_in;
            active_reg <= active_in;
        end
        if (commit)
        begin
            out_fault_reg    <= !scan_status.hit;
            out_frame_reg    <= FRAME_INDEX_W'(frame_sel);
            out_ev_valid_reg <= !scan_status.hit && evict;
            out_ev_page_reg  <= (!scan_status.hit && evict) ?
                                PAGE_NUMBER_W'(oldest_page) : '0;
            out_count_reg    <= faults_new;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.fault         = out_fault_reg;
    assign rsp.frame_index   = out_frame_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_count   = out_count_reg;

endmodule

`default_nettype wire
